// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLKRST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKRST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/uidq_pkg.sv =====
// Shared codes and controller/datapath interface types of the unique id queue.
package uidq_pkg;

   localparam logic [1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [1:0] MODE_REMOVE  = 2'd1;
   localparam logic [1:0] MODE_DRAIN   = 2'd2;
   localparam logic [1:0] MODE_QUERY   = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam int MAX_RESULTS = 16;
   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic capture;      // latch the request word
      logic search;       // register the per-cell match vector
      logic exec;         // perform a single-result operation and load its result
      logic drain_start;  // load drain length and final occupancy
      logic pop;          // pop head cell into the result register
   } cmd_type;

   typedef struct packed {
      logic is_drain;
      logic drain_empty;
      logic last_pop;
      logic slot_free;
   } stat_type;

endpackage

// ===== rtl/uidq_ctrl.sv =====
// Sequencer of the unique id queue: accept, search, execute, drain loop.
module uidq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  uidq_pkg::stat_type stat,
   output uidq_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_EXEC,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            if (stat.is_drain && !stat.drain_empty) begin
               cmd.drain_start = 1'b1;
               state_in        = S_DRAIN;
            end else if (stat.slot_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (stat.slot_free) begin
               cmd.pop = 1'b1;
               if (stat.last_pop) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/uidq_datapath.sv =====
// Datapath of the unique id queue: id cells, parallel match, compaction, result register.
module uidq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [4:0]         csr_capacity,
   input  logic [1:0]         req_mode,
   input  logic signed [63:0] req_player_id,
   input  logic [4:0]         req_count,
   input  uidq_pkg::cmd_type  cmd,
   output uidq_pkg::stat_type stat,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_position,
   output logic signed [63:0] rsp_drained_id,
   output logic               rsp_id_valid,
   output logic [4:0]         rsp_occupancy,
   output logic               rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 5) ? CW : 5;

   logic [63:0]       cell_ff [DEPTH];
   logic [63:0]       cell_in [DEPTH];
   logic [63:0]       cell_up [DEPTH];
   logic [CW-1:0]     count_ff, count_in;
   logic [4:0]        capacity_ff;
   logic [63:0]       id_ff;
   logic [1:0]        mode_ff;
   logic [4:0]        dcount_ff;
   logic [DEPTH-1:0]  match_ff, match_in;
   logic [4:0]        drain_left_ff, drain_left_in;
   logic [CW-1:0]     occ_after_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [4:0]        rsp_position_ff, rsp_position_in;
   logic [63:0]       rsp_drained_id_ff, rsp_drained_id_in;
   logic              rsp_id_valid_ff, rsp_id_valid_in;
   logic [4:0]        rsp_occupancy_ff, rsp_occupancy_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              found, full, do_append, do_remove, load;
   logic [CW-1:0]     hit_pos;
   logic [XW-1:0]     cap_x, n_first, n_x, hit_x, cnt_next_x, occ_after_x;

   // each cell's neighbor one place toward the tail
   for (genvar g = 0; g < DEPTH; g++) begin : g_up
      if (g < DEPTH - 1) begin : g_mid
         assign cell_up[g] = cell_ff[g + 1];
      end else begin : g_tail
         assign cell_up[g] = cell_ff[g];
      end
   end

   // first match wins
   always_comb begin
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_pos = CW'(i + 1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (cell_ff[i] == id_ff) && (CW'(i) < count_ff);
      end
   end

   assign found = |match_ff;
   assign cap_x = (XW'(capacity_ff) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(capacity_ff);
   assign full  = XW'(count_ff) >= cap_x;

   assign n_first = (XW'(dcount_ff) < XW'(count_ff)) ? XW'(dcount_ff) : XW'(count_ff);
   assign n_x     = (n_first > XW'(uidq_pkg::MAX_RESULTS)) ?
                    XW'(uidq_pkg::MAX_RESULTS) : n_first;

   assign do_append = cmd.exec && (mode_ff == uidq_pkg::MODE_ENQUEUE) && !found && !full;
   assign do_remove = cmd.exec && (mode_ff == uidq_pkg::MODE_REMOVE) && found;
   assign load      = cmd.exec || cmd.pop;

   assign stat.is_drain    = (mode_ff == uidq_pkg::MODE_DRAIN);
   assign stat.drain_empty = (n_x == '0);
   assign stat.last_pop    = (drain_left_ff == 5'd1);
   assign stat.slot_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (do_append && (count_ff == CW'(i))) begin
            cell_in[i] = id_ff;
         end else if (cmd.pop || (do_remove && (CW'(i + 1) >= hit_pos))) begin
            cell_in[i] = cell_up[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_append) begin
         count_in = count_ff + CW'(1);
      end else if (do_remove || cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      drain_left_in = drain_left_ff;
      if (cmd.drain_start) begin
         drain_left_in = n_x[4:0];
      end else if (cmd.pop) begin
         drain_left_in = drain_left_ff - 5'd1;
      end
   end

   assign hit_x       = XW'(hit_pos);
   assign cnt_next_x  = XW'(count_in);
   assign occ_after_x = XW'(occ_after_ff);

   always_comb begin
      rsp_status_in     = rsp_status_ff;
      rsp_position_in   = rsp_position_ff;
      rsp_drained_id_in = rsp_drained_id_ff;
      rsp_id_valid_in   = rsp_id_valid_ff;
      rsp_occupancy_in  = rsp_occupancy_ff;
      rsp_last_in       = rsp_last_ff;
      if (cmd.pop) begin
         rsp_status_in     = uidq_pkg::STATUS_OK;
         rsp_position_in   = 5'd0;
         rsp_drained_id_in = cell_ff[0];
         rsp_id_valid_in   = 1'b1;
         rsp_occupancy_in  = occ_after_x[4:0];
         rsp_last_in       = stat.last_pop;
      end else if (cmd.exec) begin
         rsp_status_in     = uidq_pkg::STATUS_OK;
         rsp_position_in   = 5'd0;
         rsp_drained_id_in = '0;
         rsp_id_valid_in   = 1'b0;
         rsp_occupancy_in  = cnt_next_x[4:0];
         rsp_last_in       = 1'b1;
         case (mode_ff)
            uidq_pkg::MODE_ENQUEUE: begin
               if (found) begin
                  rsp_status_in = uidq_pkg::STATUS_DUPLICATE;
               end else if (full) begin
                  rsp_status_in = uidq_pkg::STATUS_FULL;
               end else begin
                  rsp_position_in = cnt_next_x[4:0];
               end
            end
            uidq_pkg::MODE_REMOVE: begin
               if (!found) begin
                  rsp_status_in = uidq_pkg::STATUS_NOT_FOUND;
               end
            end
            uidq_pkg::MODE_QUERY: begin
               rsp_position_in = hit_x[4:0];
               if (!found) begin
                  rsp_status_in = uidq_pkg::STATUS_NOT_FOUND;
               end
            end
            default: begin
               // empty drain keeps the defaults above
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         capacity_ff   <= uidq_pkg::CAPACITY_RESET;
         drain_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         drain_left_ff <= drain_left_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            capacity_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff           <= cell_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_position_ff   <= rsp_position_in;
      rsp_drained_id_ff <= rsp_drained_id_in;
      rsp_id_valid_ff   <= rsp_id_valid_in;
      rsp_occupancy_ff  <= rsp_occupancy_in;
      rsp_last_ff       <= rsp_last_in;
      if (cmd.capture) begin
         id_ff     <= req_player_id;
         mode_ff   <= req_mode;
         dcount_ff <= req_count;
      end
      if (cmd.search) begin
         match_ff <= match_in;
      end
      if (cmd.drain_start) begin
         occ_after_ff <= count_ff - CW'(n_x);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_drained_id = rsp_drained_id_ff;
   assign rsp_id_valid   = rsp_id_valid_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== rtl/unique_id_fifo_with_removal.sv =====
// Top level of the bounded queue of unique 64-bit ids with removal by id.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_mode, req_player_id, req_count
//   rsp      out  rsp_valid/rsp_ready    rsp_status, rsp_position, rsp_drained_id,
//                                        rsp_id_valid, rsp_occupancy, rsp_last
//   csr      in   csr_valid/csr_ready    csr_capacity
//
// Enqueue, remove and query words go through capture, registered match over all
// cells, then execute into the result register. A drain loads its length after the
// match; the head cell is then shifted out one id per cycle while the result register is free.
// Reset clears the occupancy and sets the capacity to 16; the id cells are not cleared.
// A full result register stalls execution until rsp_ready; csr is always ready.
`include "assert_macros.svh"

module unique_id_fifo_with_removal #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [63:0] req_player_id,
   input  logic [4:0]         req_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_position,
   output logic signed [63:0] rsp_drained_id,
   output logic               rsp_id_valid,
   output logic [4:0]         rsp_occupancy,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_capacity
);

   uidq_pkg::cmd_type  cmd;
   uidq_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   uidq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   uidq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_capacity   (csr_capacity),
      .req_mode       (req_mode),
      .req_player_id  (req_player_id),
      .req_count      (req_count),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .rsp_drained_id (rsp_drained_id),
      .rsp_id_valid   (rsp_id_valid),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_last       (rsp_last)
   );

   `ASSERT_CLKRST(a_capture_then_search, clock, reset, cmd.capture |=> cmd.search, "no search")
   `ASSERT_CLKRST(a_load_slot, clock, reset, (cmd.exec || cmd.pop) |-> stat.slot_free, "slot busy")
   `ASSERT_CLKRST(a_pop_idle, clock, reset, (cmd.pop && stat.last_pop) |=> req_ready, "no idle")
   `ASSERT_CLK(a_reset_state, clock, reset |=> (!rsp_valid && req_ready), "bad state after reset")

endmodule
